[rtl/vsr_pkg.sv]
`default_nettype none

package vsr_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int NODE_W     = 10;
    localparam int POS_W      = 32;
    localparam int ACC_W      = 48;
    localparam int ONE_FX     = 1 << FRAC_BITS;
    localparam int K_STIFF    = ((32 << FRAC_BITS) + 50) / 100;
    localparam int SQRT_STEPS = 33;
    localparam int DIV_STEPS  = 17;

    localparam logic [1:0] ACT_INT  = 2'd0;
    localparam logic [1:0] ACT_EDGE = 2'd1;
    localparam logic [1:0] ACT_FIN  = 2'd2;

    localparam logic CFG_TIME_STEP = 1'b0;
    localparam logic CFG_DAMPING   = 1'b1;

    localparam logic [4:0] OP_NOP    = 5'd0;
    localparam logic [4:0] OP_CLEAR  = 5'd1;
    localparam logic [4:0] OP_LOAD   = 5'd2;
    localparam logic [4:0] OP_INT_RD = 5'd3;
    localparam logic [4:0] OP_INT_MUL = 5'd4;
    localparam logic [4:0] OP_INT_WR = 5'd5;
    localparam logic [4:0] OP_E_RDA  = 5'd6;
    localparam logic [4:0] OP_E_RDB  = 5'd7;
    localparam logic [4:0] OP_E_DIFF = 5'd8;
    localparam logic [4:0] OP_E_SQ   = 5'd9;
    localparam logic [4:0] OP_E_SUM  = 5'd10;
    localparam logic [4:0] OP_E_SQRT = 5'd11;
    localparam logic [4:0] OP_E_CHK  = 5'd12;
    localparam logic [4:0] OP_E_DIV  = 5'd13;
    localparam logic [4:0] OP_E_M1   = 5'd14;
    localparam logic [4:0] OP_E_M2   = 5'd15;
    localparam logic [4:0] OP_E_RDAC = 5'd16;
    localparam logic [4:0] OP_E_WRA  = 5'd17;
    localparam logic [4:0] OP_E_WRB  = 5'd18;
    localparam logic [4:0] OP_F_RD   = 5'd19;
    localparam logic [4:0] OP_F_CALC = 5'd20;
    localparam logic [4:0] OP_F_OUT  = 5'd21;

    typedef struct packed {
        logic [4:0] op;
        logic       ready;
    } vsr_cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       in_valid;
        logic       d_zero;
        logic       len_zero;
        logic       clr_last;
        logic       out_free;
    } vsr_sts_t;

endpackage

`default_nettype wire

[rtl/vsr_if.sv]
`default_nettype none

interface vsr_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [9:0]         node_a;
    logic [9:0]         node_b;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] grav_x;
    logic signed [31:0] grav_y;
    logic signed [31:0] grav_z;
    logic [16:0]        weight;
    logic [30:0]        rest_length;
    logic [23:0]        length_scale;

    modport source (output valid, action, node_a, node_b, pos_x, pos_y, pos_z,
                    grav_x, grav_y, grav_z, weight, rest_length, length_scale,
                    input ready);
    modport sink (input valid, action, node_a, node_b, pos_x, pos_y, pos_z,
                  grav_x, grav_y, grav_z, weight, rest_length, length_scale,
                  output ready);
endinterface

interface vsr_out_if;
    logic               valid;
    logic               ready;
    logic [9:0]         node_index;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               frozen;

    modport source (output valid, node_index, out_x, out_y, out_z, frozen, input ready);
    modport sink (input valid, node_index, out_x, out_y, out_z, frozen, output ready);
endinterface

`default_nettype wire

[rtl/vsr_ctrl.sv]
`default_nettype none

module vsr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  vsr_pkg::vsr_sts_t sts,
    output vsr_pkg::vsr_cmd_t cmd
);
    import vsr_pkg::*;

    localparam logic [4:0] S_CLEAR   = 5'd0;
    localparam logic [4:0] S_IDLE    = 5'd1;
    localparam logic [4:0] S_DISP    = 5'd2;
    localparam logic [4:0] S_INT_MUL = 5'd3;
    localparam logic [4:0] S_INT_WR  = 5'd4;
    localparam logic [4:0] S_E_RDB   = 5'd5;
    localparam logic [4:0] S_E_DIFF  = 5'd6;
    localparam logic [4:0] S_E_SQ    = 5'd7;
    localparam logic [4:0] S_E_SUM   = 5'd8;
    localparam logic [4:0] S_E_SQRT  = 5'd9;
    localparam logic [4:0] S_E_CHK   = 5'd10;
    localparam logic [4:0] S_E_DIV   = 5'd11;
    localparam logic [4:0] S_E_M1    = 5'd12;
    localparam logic [4:0] S_E_M2    = 5'd13;
    localparam logic [4:0] S_E_RDAC  = 5'd14;
    localparam logic [4:0] S_E_WRA   = 5'd15;
    localparam logic [4:0] S_E_WRB   = 5'd16;
    localparam logic [4:0] S_F_CALC  = 5'd17;
    localparam logic [4:0] S_F_OUT   = 5'd18;

    logic [4:0] state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd.op     = OP_NOP;
        cmd.ready  = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.op = OP_CLEAR;
                if (sts.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                cmd.ready = 1'b1;
                if (sts.in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (sts.action)
                    ACT_INT:
                    begin
                        cmd.op     = OP_INT_RD;
                        state_next = S_INT_MUL;
                    end
                    ACT_EDGE:
                    begin
                        cmd.op     = OP_E_RDA;
                        state_next = S_E_RDB;
                    end
                    ACT_FIN:
                    begin
                        cmd.op     = OP_F_RD;
                        state_next = S_F_CALC;
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_INT_MUL:
            begin
                cmd.op     = OP_INT_MUL;
                state_next = S_INT_WR;
            end
            S_INT_WR:
            begin
                cmd.op     = OP_INT_WR;
                state_next = S_IDLE;
            end
            S_E_RDB:
            begin
                cmd.op     = OP_E_RDB;
                state_next = S_E_DIFF;
            end
            S_E_DIFF:
            begin
                cmd.op     = OP_E_DIFF;
                state_next = S_E_SQ;
            end
            S_E_SQ:
            begin
                if (sts.d_zero)
                    state_next = S_IDLE;
                else
                begin
                    cmd.op     = OP_E_SQ;
                    state_next = S_E_SUM;
                end
            end
            S_E_SUM:
            begin
                cmd.op     = OP_E_SUM;
                cnt_next   = '0;
                state_next = S_E_SQRT;
            end
            S_E_SQRT:
            begin
                cmd.op   = OP_E_SQRT;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(SQRT_STEPS - 1))
                    state_next = S_E_CHK;
            end
            S_E_CHK:
            begin
                cnt_next = '0;
                if (sts.len_zero)
                    state_next = S_IDLE;
                else
                begin
                    cmd.op     = OP_E_CHK;
                    state_next = S_E_DIV;
                end
            end
            S_E_DIV:
            begin
                cmd.op   = OP_E_DIV;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(DIV_STEPS - 1))
                    state_next = S_E_M1;
            end
            S_E_M1:
            begin
                cmd.op     = OP_E_M1;
                state_next = S_E_M2;
            end
            S_E_M2:
            begin
                cmd.op     = OP_E_M2;
                state_next = S_E_RDAC;
            end
            S_E_RDAC:
            begin
                cmd.op     = OP_E_RDAC;
                state_next = S_E_WRA;
            end
            S_E_WRA:
            begin
                cmd.op     = OP_E_WRA;
                state_next = S_E_WRB;
            end
            S_E_WRB:
            begin
                cmd.op     = OP_E_WRB;
                state_next = S_IDLE;
            end
            S_F_CALC:
            begin
                cmd.op     = OP_F_CALC;
                state_next = S_F_OUT;
            end
            S_F_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = OP_F_OUT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

[rtl/vsr_datapath.sv]
`default_nettype none

module vsr_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [23:0]       cfg_data,
    vsr_in_if.sink            items,
    vsr_out_if.source         results,
    input  vsr_pkg::vsr_cmd_t cmd,
    output vsr_pkg::vsr_sts_t sts
);
    import vsr_pkg::*;

    function automatic logic [31:0] sat32(input logic signed [50:0] v);
        logic [31:0] r;
        if (v[50:31] == {20{v[31]}})
            r = v[31:0];
        else if (v[50])
            r = 32'h8000_0000;
        else
            r = 32'h7FFF_FFFF;
        return r;
    endfunction

    function automatic logic [47:0] sat48(input logic signed [48:0] v);
        logic [47:0] r;
        if (v[48] == v[47])
            r = v[47:0];
        else if (v[48])
            r = 48'h8000_0000_0000;
        else
            r = 48'h7FFF_FFFF_FFFF;
        return r;
    endfunction

    // Configuration registers.
    logic [23:0] ts_reg;
    logic [16:0] ds_reg;

    // Captured item.
    logic [1:0]         act_reg;
    logic [9:0]         a_reg, b_reg;
    logic signed [31:0] pos_reg [3];
    logic signed [31:0] grav_reg [3];
    logic [16:0]        w_reg;
    logic [30:0]        rl_reg;
    logic [23:0]        ls_reg;

    // Memories.
    logic [95:0]  store_mem [1024];
    logic [143:0] acc_mem [1024];
    logic [95:0]  store_rd_reg;
    logic [143:0] acc_rd_reg;
    logic         st_re, st_we, ac_re, ac_we;
    logic [9:0]   st_raddr, ac_raddr, ac_waddr;
    logic [95:0]  st_wdata;
    logic [143:0] ac_wdata;
    logic [9:0]   clr_addr_reg;

    // Arithmetic registers.
    logic signed [35:0] f1p_reg;
    logic [47:0]        dt2p_reg;
    logic signed [52:0] velp_reg [3];
    logic signed [64:0] gp_reg [3];
    logic [54:0]        restp_reg;
    logic [31:0]        sp_reg;
    logic [95:0]        sa_reg;
    logic               neg_reg [3];
    logic [32:0]        mag_reg [3];
    logic               nz_reg [3];
    logic [65:0]        sq_reg [3];
    logic [65:0]        rad_reg;
    logic [34:0]        rem_reg;
    logic [32:0]        root_reg;
    logic [38:0]        diff_reg;
    logic               gt_reg;
    logic [34:0]        drem_reg [3];
    logic [16:0]        q_reg [3];
    logic [55:0]        cp_reg [3];
    logic [55:0]        mp_reg [3];
    logic signed [40:0] corr_reg [3];
    logic [31:0]        res_reg [3];
    logic               frz_reg;

    // Result register.
    logic        out_valid_reg;
    logic [9:0]  out_node_reg;
    logic [31:0] out_pos_reg [3];
    logic        out_frz_reg;

    // Combinational values.
    logic signed [17:0] omw;
    logic signed [19:0] f1;
    logic [31:0]        dt2;
    logic [15:0]        s_val;
    logic [38:0]        rest_val;
    logic signed [32:0] dpos [3];
    logic [31:0]        int_new [3];
    logic signed [32:0] ed [3];
    logic [32:0]        ed_mag [3];
    logic [47:0]        acc_a_new [3];
    logic [47:0]        acc_b_new [3];
    logic [31:0]        fin_new [3];
    logic               frozen_now;
    logic [36:0]        remv, trial;
    logic               sq_ge;
    logic [34:0]        dsub [3];
    logic [34:0]        drem_next [3];
    logic [16:0]        q_next [3];
    logic [39:0]        m_val [3];

    assign omw        = 18'sd65536 - $signed({1'b0, w_reg});
    assign f1         = f1p_reg[35:FRAC_BITS];
    assign dt2        = dt2p_reg[47:FRAC_BITS];
    assign s_val      = sp_reg[31:FRAC_BITS];
    assign rest_val   = restp_reg[54:FRAC_BITS];
    assign frozen_now = w_reg[16];
    assign remv       = {rem_reg, rad_reg[65:64]};
    assign trial      = {2'b00, root_reg, 2'b01};
    assign sq_ge      = remv >= trial;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dpos[i] = {pos_reg[i][31], pos_reg[i]}
                    - $signed({store_rd_reg[32*i+31], store_rd_reg[32*i +: 32]});
            int_new[i] = sat32(51'(pos_reg[i])
                             + 51'($signed(velp_reg[i][52:FRAC_BITS]))
                             + 51'($signed(gp_reg[i][64:FRAC_BITS])));
            ed[i] = $signed({sa_reg[32*i+31], sa_reg[32*i +: 32]})
                  - $signed({store_rd_reg[32*i+31], store_rd_reg[32*i +: 32]});
            ed_mag[i] = ed[i][32] ? 33'(-ed[i]) : 33'(ed[i]);
            acc_a_new[i] = sat48(49'($signed(acc_rd_reg[48*i +: 48])) - 49'(corr_reg[i]));
            acc_b_new[i] = sat48(49'($signed(acc_rd_reg[48*i +: 48])) + 49'(corr_reg[i]));
            fin_new[i] = sat32(51'($signed(store_rd_reg[32*i +: 32]))
                             + 51'($signed(acc_rd_reg[48*i +: 48])));
            dsub[i] = (drem_reg[i] >= {2'b00, root_reg})
                    ? drem_reg[i] - {2'b00, root_reg} : drem_reg[i];
            drem_next[i] = {dsub[i][33:0], 1'b0};
            q_next[i] = {q_reg[i][15:0], drem_reg[i] >= {2'b00, root_reg}};
            m_val[i] = mp_reg[i][55:FRAC_BITS];
        end
    end

    // Memory port control.
    always_comb
    begin
        st_re    = (cmd.op == OP_INT_RD) || (cmd.op == OP_E_RDA)
                || (cmd.op == OP_E_RDB) || (cmd.op == OP_F_RD);
        st_raddr = (cmd.op == OP_E_RDB) ? b_reg : a_reg;
        st_we    = (cmd.op == OP_INT_WR) || ((cmd.op == OP_F_CALC) && !frozen_now);
        st_wdata = (cmd.op == OP_INT_WR) ? {int_new[2], int_new[1], int_new[0]}
                                         : {fin_new[2], fin_new[1], fin_new[0]};
        ac_re    = (cmd.op == OP_E_RDAC) || (cmd.op == OP_E_WRA) || (cmd.op == OP_F_RD);
        ac_raddr = (cmd.op == OP_E_WRA) ? b_reg : a_reg;
        ac_we    = 1'b0;
        ac_waddr = a_reg;
        ac_wdata = '0;
        unique case (cmd.op)
            OP_CLEAR:
            begin
                ac_we    = 1'b1;
                ac_waddr = clr_addr_reg;
            end
            OP_INT_WR: ac_we = 1'b1;
            OP_E_WRA:
            begin
                ac_we    = 1'b1;
                ac_wdata = {acc_a_new[2], acc_a_new[1], acc_a_new[0]};
            end
            OP_E_WRB:
            begin
                ac_we    = 1'b1;
                ac_waddr = b_reg;
                ac_wdata = {acc_b_new[2], acc_b_new[1], acc_b_new[0]};
            end
            default: ac_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
            store_mem[a_reg] <= st_wdata;
        if (st_re)
            store_rd_reg <= store_mem[st_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ac_we)
            acc_mem[ac_waddr] <= ac_wdata;
        if (ac_re)
            acc_rd_reg <= acc_mem[ac_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ts_reg        <= 24'd65536;
            ds_reg        <= 17'd65536;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_TIME_STEP: ts_reg <= cfg_data;
                    CFG_DAMPING:   ds_reg <= cfg_data[16:0];
                    default:       ts_reg <= ts_reg;
                endcase
            end
            if (cmd.op == OP_CLEAR)
                clr_addr_reg <= clr_addr_reg + 10'd1;
            if (cmd.op == OP_F_OUT)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                act_reg     <= items.action;
                a_reg       <= items.node_a;
                b_reg       <= items.node_b;
                pos_reg[0]  <= items.pos_x;
                pos_reg[1]  <= items.pos_y;
                pos_reg[2]  <= items.pos_z;
                grav_reg[0] <= items.grav_x;
                grav_reg[1] <= items.grav_y;
                grav_reg[2] <= items.grav_z;
                w_reg       <= items.weight;
                rl_reg      <= items.rest_length;
                ls_reg      <= items.length_scale;
            end
            OP_INT_RD:
            begin
                f1p_reg  <= omw * $signed({1'b0, ds_reg});
                dt2p_reg <= ts_reg * ts_reg;
            end
            OP_INT_MUL:
            begin
                // With a zero damping factor the previous position plays no part.
                for (int i = 0; i < 3; i++)
                begin
                    velp_reg[i] <= (f1 == '0) ? 53'sd0 : dpos[i] * f1;
                    gp_reg[i]   <= grav_reg[i] * $signed({1'b0, dt2});
                end
            end
            OP_E_RDA:
            begin
                restp_reg <= rl_reg * ls_reg;
                sp_reg    <= w_reg * 15'(K_STIFF);
            end
            OP_E_RDB: sa_reg <= store_rd_reg;
            OP_E_DIFF:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    neg_reg[i] <= ed[i][32];
                    mag_reg[i] <= ed_mag[i];
                    nz_reg[i]  <= ed[i] != '0;
                end
            end
            OP_E_SQ:
            begin
                for (int i = 0; i < 3; i++)
                    sq_reg[i] <= mag_reg[i] * mag_reg[i];
            end
            OP_E_SUM:
            begin
                rad_reg  <= sq_reg[0] + sq_reg[1] + sq_reg[2];
                rem_reg  <= '0;
                root_reg <= '0;
            end
            OP_E_SQRT:
            begin
                rad_reg <= {rad_reg[63:0], 2'b00};
                if (sq_ge)
                begin
                    rem_reg  <= 35'(remv - trial);
                    root_reg <= {root_reg[31:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= remv[34:0];
                    root_reg <= {root_reg[31:0], 1'b0};
                end
            end
            OP_E_CHK:
            begin
                gt_reg   <= {6'd0, root_reg} > rest_val;
                diff_reg <= ({6'd0, root_reg} > rest_val) ? {6'd0, root_reg} - rest_val
                                                          : rest_val - {6'd0, root_reg};
                for (int i = 0; i < 3; i++)
                begin
                    drem_reg[i] <= {2'b00, mag_reg[i]};
                    q_reg[i]    <= '0;
                end
            end
            OP_E_DIV:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    drem_reg[i] <= drem_next[i];
                    q_reg[i]    <= q_next[i];
                end
            end
            OP_E_M1:
            begin
                for (int i = 0; i < 3; i++)
                    cp_reg[i] <= q_reg[i] * diff_reg;
            end
            OP_E_M2:
            begin
                for (int i = 0; i < 3; i++)
                    mp_reg[i] <= cp_reg[i][55:FRAC_BITS] * s_val;
            end
            OP_E_RDAC:
            begin
                for (int i = 0; i < 3; i++)
                    corr_reg[i] <= (gt_reg ^ neg_reg[i]) ? $signed({1'b0, m_val[i]})
                                                         : -$signed({1'b0, m_val[i]});
            end
            OP_F_CALC:
            begin
                frz_reg <= frozen_now;
                for (int i = 0; i < 3; i++)
                    res_reg[i] <= frozen_now ? store_rd_reg[32*i +: 32] : fin_new[i];
            end
            OP_F_OUT:
            begin
                out_node_reg <= a_reg;
                out_frz_reg  <= frz_reg;
                for (int i = 0; i < 3; i++)
                    out_pos_reg[i] <= res_reg[i];
            end
            default: frz_reg <= frz_reg;
        endcase
    end

    assign items.ready        = cmd.ready;
    assign results.valid      = out_valid_reg;
    assign results.node_index = out_node_reg;
    assign results.out_x      = out_pos_reg[0];
    assign results.out_y      = out_pos_reg[1];
    assign results.out_z      = out_pos_reg[2];
    assign results.frozen     = out_frz_reg;

    assign sts.action   = act_reg;
    assign sts.in_valid = items.valid;
    assign sts.d_zero   = !(nz_reg[0] || nz_reg[1] || nz_reg[2]);
    assign sts.len_zero = root_reg == '0;
    assign sts.clr_last = clr_addr_reg == '1;
    assign sts.out_free = !out_valid_reg || results.ready;

endmodule

`default_nettype wire

[rtl/verlet_spring_relax_step.sv]
`default_nettype none

// Channel   Direction  Moves
// items     in         one integrate, edge or finalize item per transfer
// results   out        one final node position per finalize transfer
// cfg_*     in         register writes, one per cycle with cfg_we high
//
// Integrate reads, updates and writes back a node; finalize reads, computes and may
// wait for the result register; an edge runs through the 33-step square-root unit
// and the 17-step divider.
// After reset a pass clears all 1024 accumulator entries before items are taken.
// A waiting result does not block new items until the next finalize.

module verlet_spring_relax_step (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [23:0] cfg_data,
    vsr_in_if.sink      items,
    vsr_out_if.source   results
);
    import vsr_pkg::*;

    vsr_cmd_t cmd;
    vsr_sts_t sts;

    vsr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    vsr_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .items     (items),
        .results   (results),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire
